// ===== rtl/lwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared types and constants of the LZSS window decoder: window geometry,
// pair field widths, sequencer states and the inter-module structs.
// ----------------------------------------------------------------------------
package lwd_pkg;

	// history window geometry
	localparam int WINDOW_DEPTH = 4096;
	localparam int POS_W        = $clog2(WINDOW_DEPTH);

	// pair fields
	localparam int OFFSET_W  = 12;
	localparam int LEN_W     = 5;
	localparam int MIN_MATCH = 3;
	localparam int FLAG_CNT  = 8;
	localparam int FLAGS_W   = 4;

	// copy sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COPY
	} lwd_state_t;

	// history memory request
	typedef struct packed {
		logic             we;
		logic [POS_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [POS_W-1:0] raddr;
	} lwd_mem_req_t;

	// one decoded byte toward the output register
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} lwd_emit_t;

endpackage

// ===== rtl/lzss_window_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS decoder with a 4096-byte circular history, one compressed byte per
// input transaction and one decoded byte per output transaction.
// ----------------------------------------------------------------------------
// A flag byte, a literal and the first byte of a pair are each taken in the
// idle state; a literal is emitted at once. The second byte of a pair starts
// a copy of 3 to 18 bytes: the first history read in ST_READ, then one
// copied byte per cycle in ST_COPY, limited by the single read and write port of the
// history RAM and the one source address adder. Output stall holds the copy
// in place. History needs no clearing after reset. run_last marks the final
// byte produced by each input transaction.
module lzss_window_decoder
	import lwd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	lwd_mem_req_t mem_req;
	lwd_emit_t    emit;
	logic [7:0]   rd_data;
	logic         in_ready;
	logic         slot_free;
	logic         out_valid_q;
	logic [7:0]   out_byte_q;
	logic         run_last_q;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !in_ready;

	lwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_byte   (in_byte),
		.in_ready  (in_ready),
		.slot_free (slot_free),
		.rd_data   (rd_data),
		.mem_req   (mem_req),
		.emit      (emit)
	);

	lwd_history u_history (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_byte_q <= emit.data;
			run_last_q <= emit.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

// ===== rtl/lwd_history.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_history
// Circular history of decoded bytes: one write and one registered read per
// cycle, with a bypass for a read that hits the address written that cycle.
// ----------------------------------------------------------------------------
module lwd_history
	import lwd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  lwd_mem_req_t req,
	output logic [7:0]   rd_data
);

	logic [7:0] mem_q [WINDOW_DEPTH];
	logic [7:0] rd_q;
	logic [7:0] byp_data_q;
	logic       byp_q;

	// memory array: write port and registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem_q[req.raddr];
		end
	end

	// read-during-write to the same entry returns the new byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (req.re) begin
			byp_q <= req.we && (req.waddr == req.raddr);
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			byp_data_q <= req.wdata;
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

// ===== rtl/lwd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_ctrl
// Stream parser and copy sequencer. Tracks flag bits, collects pairs and runs
// a copy one byte per unstalled cycle through a shared source address adder.
// ----------------------------------------------------------------------------
module lwd_ctrl
	import lwd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [7:0]   in_byte,
	output logic         in_ready,
	input  logic         slot_free,
	input  logic [7:0]   rd_data,
	output lwd_mem_req_t mem_req,
	output lwd_emit_t    emit
);

	lwd_state_t         state_q, state_d;
	logic [7:0]         flag_bits_q;
	logic [FLAGS_W-1:0] flags_left_q;
	logic               pair_pending_q;
	logic [7:0]         offset_low_q;
	logic [OFFSET_W-1:0] off_q;
	logic [LEN_W-1:0]   cnt_q;
	logic [POS_W-1:0]   wp_q;
	logic               accept;
	logic               copy_last;
	logic [POS_W-1:0]   src_addr;

	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign copy_last = (cnt_q == LEN_W'(1));

	// shared source adder: write position + offset, plus one while copying
	assign src_addr = wp_q + POS_W'(off_q) + POS_W'(state_q == ST_COPY);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && pair_pending_q) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_COPY;
			end
			ST_COPY: begin
				if (slot_free && copy_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory requests and emitted bytes
	always_comb begin
		mem_req = '0;
		emit    = '0;
		case (state_q)
			ST_IDLE: begin
				// literal
				if (accept && !pair_pending_q && (flags_left_q != '0) && !flag_bits_q[0]) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = wp_q;
					mem_req.wdata = in_byte;
					emit.valid    = 1'b1;
					emit.data     = in_byte;
					emit.last     = 1'b1;
				end
			end
			ST_READ: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = src_addr;
			end
			ST_COPY: begin
				if (slot_free) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = wp_q;
					mem_req.wdata = rd_data;
					emit.valid    = 1'b1;
					emit.data     = rd_data;
					emit.last     = copy_last;
					if (!copy_last) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = src_addr;
					end
				end
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			flag_bits_q    <= '0;
			flags_left_q   <= '0;
			pair_pending_q <= 1'b0;
			offset_low_q   <= '0;
			wp_q           <= '0;
			cnt_q          <= '0;
			off_q          <= '0;
		end else begin
			state_q <= state_d;
			if (mem_req.we) begin
				wp_q <= wp_q + POS_W'(1);
			end
			if ((state_q == ST_COPY) && slot_free) begin
				cnt_q <= cnt_q - LEN_W'(1);
			end
			if (accept) begin
				if (pair_pending_q) begin
					// second pair byte: start the copy
					off_q          <= {in_byte[7:4], offset_low_q};
					cnt_q          <= LEN_W'(in_byte[3:0]) + LEN_W'(MIN_MATCH);
					pair_pending_q <= 1'b0;
					flag_bits_q    <= flag_bits_q >> 1;
					flags_left_q   <= flags_left_q - FLAGS_W'(1);
				end else if (flags_left_q == '0) begin
					flag_bits_q  <= in_byte;
					flags_left_q <= FLAGS_W'(FLAG_CNT);
				end else if (flag_bits_q[0]) begin
					offset_low_q   <= in_byte;
					pair_pending_q <= 1'b1;
				end else begin
					flag_bits_q  <= flag_bits_q >> 1;
					flags_left_q <= flags_left_q - FLAGS_W'(1);
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// a running copy always has bytes left
	a_copy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> (cnt_q != '0))
		else $error("copy running with zero count");

	// nothing is emitted unless the output register can take it
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> slot_free)
		else $error("byte emitted into a full output register");

	// the last copied byte returns the sequencer to idle
	a_copy_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_COPY) && slot_free && copy_last) |=> (state_q == ST_IDLE))
		else $error("copy did not end after its last byte");
`endif

endmodule

// ===== test/lzss_window_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decoder_tb
// Self-checking bench for the LZSS window decoder. Compressed streams are
// built so that every copy reads only history that was already written. A
// local decoder model with its own window predicts each output transaction,
// and the checker compares it field by field. Covers literals, short and long
// overlapping pairs, window wrap, zero offset and a truncated final pair,
// with random input gaps and output stalls in all but the last phase.
// ----------------------------------------------------------------------------
module lzss_window_decoder_tb
	import lwd_pkg::*;
();

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} dec_byte_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	// decoder model state
	logic [7:0]          flag_reg;
	int                  flags_left;
	logic                pair_wait;
	logic [7:0]          offset_lo;
	logic [POS_W-1:0]    wr_pos;
	logic [7:0]          window [WINDOW_DEPTH];
	int                  decoded_cnt;
	dec_byte_t           exp_out [$];

	int         send_idle_pct;
	int         recv_stall_pct;
	int         sent_cnt;
	int         mismatches;
	logic [7:0] got_byte;
	logic       got_last;

	lzss_window_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// random backpressure on the output channel
	always @(posedge clk) begin
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// one model step: write one decoded byte into the window and queue it
	task automatic store_byte(input logic [7:0] v, input logic last);
		dec_byte_t rec;
		window[wr_pos] = v;
		wr_pos = wr_pos + 1'b1;
		if (decoded_cnt < WINDOW_DEPTH)
			decoded_cnt++;
		rec.data = v;
		rec.last = last;
		exp_out.push_back(rec);
	endtask

	task automatic next_flag();
		flag_reg = flag_reg >> 1;
		if (flags_left > 0)
			flags_left--;
	endtask

	task automatic decode_in_byte(input logic [7:0] b);
		logic [OFFSET_W-1:0] ofs;
		logic [POS_W-1:0]    src;
		int                  len;
		if (pair_wait) begin
			ofs = {b[7:4], offset_lo};
			len = int'(b[3:0]) + MIN_MATCH;
			for (int k = 0; k < len; k++) begin
				src = wr_pos + ofs;
				store_byte(window[src], k == len - 1);
			end
			pair_wait = 1'b0;
			next_flag();
		end else if (flags_left == 0) begin
			flag_reg   = b;
			flags_left = FLAG_CNT;
		end else if (flag_reg[0]) begin
			offset_lo = b;
			pair_wait = 1'b1;
		end else begin
			store_byte(b, 1'b1);
			next_flag();
		end
	endtask

	// drive one input transaction, then maybe leave a gap
	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		decode_in_byte(b);
		sent_cnt++;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_pair(input logic [OFFSET_W-1:0] ofs, input logic [3:0] len_code);
		send_byte(ofs[7:0]);
		send_byte({ofs[11:8], len_code});
	endtask

	// offset whose source bytes are all written before they are read
	function automatic logic [OFFSET_W-1:0] pick_offset(input int len);
		int span;
		int d;
		if (decoded_cnt >= WINDOW_DEPTH) begin
			case ($urandom_range(3))
				0:       return '0;
				1:       return '1;
				default: return OFFSET_W'($urandom());
			endcase
		end
		span = decoded_cnt;
		if ($urandom_range(1))
			d = $urandom_range(1, (span < len) ? span : len);
		else
			d = $urandom_range(1, span);
		return OFFSET_W'(WINDOW_DEPTH - d);
	endfunction

	// send the next well-formed entry, or a stray byte once the window is full
	task automatic send_entry(input int pair_pct, input int long_pct, input int noise_pct);
		logic [7:0] fb;
		logic [3:0] len_code;
		if (decoded_cnt >= WINDOW_DEPTH && $urandom_range(99) < noise_pct) begin
			send_byte(8'($urandom()));
		end else if (pair_wait) begin
			send_byte(8'($urandom()));
		end else if (flags_left == 0) begin
			for (int i = 0; i < 8; i++)
				fb[i] = ($urandom_range(99) < pair_pct);
			// nothing to copy from yet
			if (decoded_cnt == 0)
				fb[0] = 1'b0;
			send_byte(fb);
		end else if (flag_reg[0]) begin
			len_code = ($urandom_range(99) < long_pct) ? 4'hf : 4'($urandom_range(15));
			send_pair(pick_offset(int'(len_code) + MIN_MATCH), len_code);
		end else begin
			send_byte(8'($urandom()));
		end
	endtask

	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (exp_out.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// a flag byte of all literals, with extreme and alternating values
	task automatic test_literals();
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h55);
		send_byte(8'haa);
		send_byte(8'h7f);
		send_byte(8'hfe);
	endtask

	// shortest and longest copies, overlapping and reaching back to position 0
	task automatic test_overlapping_pairs();
		send_byte(8'h8f);
		send_pair(OFFSET_W'(WINDOW_DEPTH - 1), 4'h0);
		send_pair(OFFSET_W'(WINDOW_DEPTH - 8), 4'hf);
		send_pair(OFFSET_W'(WINDOW_DEPTH - 3), 4'h5);
		send_pair(OFFSET_W'(WINDOW_DEPTH - decoded_cnt), 4'h7);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h5a);
		send_pair(OFFSET_W'(WINDOW_DEPTH - 2), 4'hf);
	endtask

	// longest copies only, until the whole window is written and wr_pos wrapped
	task automatic test_window_wrap();
		while (decoded_cnt < WINDOW_DEPTH || wr_pos < 64)
			send_entry(100, 100, 0);
	endtask

	// mixed entries with random offsets, zero offset and stray bytes
	task automatic test_random_stream(input int n);
		int start;
		start = sent_cnt;
		while (sent_cnt - start < n)
			send_entry(50, 25, 10);
	endtask

	// stream ends right after the first byte of a pair
	task automatic test_truncated_pair();
		while (pair_wait || flags_left == 0 || !flag_reg[0])
			send_entry(75, 50, 0);
		send_byte(8'($urandom()));
	endtask

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_byte = out_byte;
			got_last = run_last;
			#1;
			if (exp_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected output byte %02h last %0b",
						$realtime, got_byte, got_last);
			end else begin
				if (exp_out[0].data !== got_byte || exp_out[0].last !== got_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: byte exp %02h got %02h, last exp %0b got %0b",
							$realtime, exp_out[0].data, got_byte, exp_out[0].last,
							got_last);
				end
				void'(exp_out.pop_front());
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_byte     = 8'h00;
		flag_reg    = '0;
		flags_left  = 0;
		pair_wait   = 1'b0;
		offset_lo   = '0;
		wr_pos      = '0;
		decoded_cnt = 0;
		sent_cnt    = 0;
		mismatches  = 0;
		set_idling(0, 0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(14, 49);
		test_literals();
		test_overlapping_pairs();
		test_window_wrap();
		drain_outputs();

		set_idling(49, 14);
		test_random_stream(30);
		drain_outputs();

		set_idling(0, 0);
		test_random_stream(20);
		test_truncated_pair();
		drain_outputs();
		repeat (40) @(posedge clk);

		if (mismatches == 0 && exp_out.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
